>>> rtl/cmr3d_pkg.sv
// ----------------------------------------------------------------------------
// cmr3d_pkg
// Shared types and constants for the centroid and max-radius block: controller
// states, the controller-to-datapath command word and parameter defaults.
// ----------------------------------------------------------------------------
package cmr3d_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_WIDTH_DEF = 24;

    // cycles from the last store read until the running maximum is final
    localparam int DRAIN_CYCLES = 5;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DIV_LOAD,
        ST_DIV,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic center_load;
        logic scan_issue;
        logic sqrt_load;
        logic sqrt_step;
        logic finish;
    } cmd_t;

endpackage

>>> rtl/cmr3d_dp.sv
// ----------------------------------------------------------------------------
// cmr3d_dp
// Datapath: point store, axis sums, three bit-serial dividers, a five-stage
// squared-distance scan with running maximum, and a bit-pair square root.
// ----------------------------------------------------------------------------
module cmr3d_dp #(
    parameter int MAX_POINTS  = cmr3d_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = cmr3d_pkg::COORD_WIDTH_DEF,
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmr3d_pkg::cmd_t               cmd,
    input  logic [ADDR_W-1:0]             scan_addr,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic [CNT_W-1:0]              count,
    output logic signed [COORD_WIDTH-1:0] center_x,
    output logic signed [COORD_WIDTH-1:0] center_y,
    output logic signed [COORD_WIDTH-1:0] center_z,
    output logic [COORD_WIDTH:0]          max_distance,
    output logic                          overflowed
);

    localparam int W     = COORD_WIDTH;
    localparam int SUM_W = W + CNT_W;
    localparam int D2_W  = 2 * W + 2;
    localparam int SQ_W  = (D2_W > 64) ? 64 : D2_W;
    localparam int R_W   = (SQ_W + 1) / 2;
    localparam int RAD_W = 2 * R_W;
    localparam int MD_W  = W + 1;

    logic signed [W-1:0]     pt [3];
    logic [CNT_W-1:0]        count_reg;
    logic                    overflow_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic                    has_room;

    logic [3*W-1:0]          store_mem [MAX_POINTS];
    logic [3*W-1:0]          rd_reg;

    logic [SUM_W-1:0]        quo_reg [3];
    logic [CNT_W-1:0]        rem_reg [3];
    logic                    neg_reg [3];
    logic [CNT_W:0]          drem_sh [3];
    logic [CNT_W:0]          drem_sub [3];
    logic                    dge [3];
    logic [SUM_W-1:0]        quo_fin [3];
    logic signed [W-1:0]     center_reg [3];

    logic [3:0]              vld_reg;
    logic signed [W:0]       diff [3];
    logic [W:0]              mag [3];
    logic [W-1:0]            dabs_reg [3];
    logic [2*W-1:0]          sq_reg [3];
    logic [D2_W-1:0]         d2_reg;
    logic [D2_W-1:0]         best_reg;

    logic [SQ_W-1:0]         sq_in;
    logic [RAD_W-1:0]        rad_reg;
    logic [R_W:0]            srem_reg;
    logic [R_W-1:0]          root_reg;
    logic [R_W+2:0]          srem_sh;
    logic [R_W+2:0]          strial;
    logic [R_W+2:0]          srem_sub;
    logic                    sge;
    logic [R_W+MD_W-1:0]     root_ext;

    logic signed [W-1:0]     out_center_reg [3];
    logic [MD_W-1:0]         out_dist_reg;
    logic                    out_ovf_reg;

    assign pt[0]    = point_x;
    assign pt[1]    = point_y;
    assign pt[2]    = point_z;
    assign has_room = (count_reg < CNT_W'(MAX_POINTS));
    assign count    = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (cmd.finish)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            if (has_room)
            begin
                count_reg <= count_reg + 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    sum_reg[a] <= sum_reg[a] + {{(SUM_W-W){pt[a][W-1]}}, pt[a]};
                end
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && has_room)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= {pt[2], pt[1], pt[0]};
        end
        rd_reg <= store_mem[scan_addr];
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            drem_sh[a]  = {rem_reg[a], quo_reg[a][SUM_W-1]};
            drem_sub[a] = drem_sh[a] - {1'b0, count_reg};
            dge[a]      = (drem_sh[a] >= {1'b0, count_reg});
            quo_fin[a]  = neg_reg[a] ? (~quo_reg[a] + 1'b1) : quo_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (cmd.div_load)
            begin
                neg_reg[a] <= sum_reg[a][SUM_W-1];
                quo_reg[a] <= sum_reg[a][SUM_W-1] ? (~sum_reg[a] + 1'b1) : sum_reg[a];
                rem_reg[a] <= '0;
            end
            else if (cmd.div_step)
            begin
                quo_reg[a] <= {quo_reg[a][SUM_W-2:0], dge[a]};
                rem_reg[a] <= dge[a] ? drem_sub[a][CNT_W-1:0] : drem_sh[a][CNT_W-1:0];
            end
            if (cmd.center_load)
            begin
                center_reg[a] <= quo_fin[a][W-1:0];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = {rd_reg[a*W+W-1], rd_reg[a*W +: W]}
                    - {center_reg[a][W-1], center_reg[a]};
            mag[a]  = diff[a][W] ? (~diff[a] + 1'b1) : diff[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], cmd.scan_issue};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            dabs_reg[a] <= mag[a][W-1:0];
            sq_reg[a]   <= dabs_reg[a] * dabs_reg[a];
        end
        d2_reg <= D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
        if (cmd.center_load)
        begin
            best_reg <= '0;
        end
        else if (vld_reg[3] && (d2_reg > best_reg))
        begin
            best_reg <= d2_reg;
        end
    end

    generate
        if (D2_W > SQ_W)
        begin : g_sat
            assign sq_in = (|best_reg[D2_W-1:SQ_W]) ? '1 : best_reg[SQ_W-1:0];
        end
        else
        begin : g_nosat
            assign sq_in = best_reg[SQ_W-1:0];
        end
    endgenerate

    assign srem_sh  = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign strial   = {1'b0, root_reg, 2'b01};
    assign srem_sub = srem_sh - strial;
    assign sge      = (srem_sh >= strial);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            rad_reg  <= RAD_W'(sq_in);
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            srem_reg <= sge ? srem_sub[R_W:0] : srem_sh[R_W:0];
            root_reg <= {root_reg[R_W-2:0], sge};
        end
    end

    assign root_ext = {{MD_W{1'b0}}, root_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            for (int a = 0; a < 3; a++)
            begin
                out_center_reg[a] <= center_reg[a];
            end
            out_dist_reg <= root_ext[MD_W-1:0];
            out_ovf_reg  <= overflow_reg;
        end
    end

    assign center_x     = out_center_reg[0];
    assign center_y     = out_center_reg[1];
    assign center_z     = out_center_reg[2];
    assign max_distance = out_dist_reg;
    assign overflowed   = out_ovf_reg;

endmodule

>>> rtl/cmr3d_ctrl.sv
// ----------------------------------------------------------------------------
// cmr3d_ctrl
// Controller: sequences loading, division, the store scan, the drain, the
// square root and the result hand-off; owns the step counter and out_valid.
// ----------------------------------------------------------------------------
module cmr3d_ctrl #(
    parameter int MAX_POINTS  = cmr3d_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = cmr3d_pkg::COORD_WIDTH_DEF,
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_point,
    input  logic              out_stall,
    input  logic [CNT_W-1:0]  count,
    output logic              in_stall,
    output logic              out_valid,
    output cmr3d_pkg::cmd_t   cmd,
    output logic [ADDR_W-1:0] scan_addr
);

    localparam int SUM_W = COORD_WIDTH + CNT_W;
    localparam int D2_W  = 2 * COORD_WIDTH + 2;
    localparam int SQ_W  = (D2_W > 64) ? 64 : D2_W;
    localparam int R_W   = (SQ_W + 1) / 2;
    localparam int CTR_W = (CNT_W > 7) ? CNT_W : 7;

    cmr3d_pkg::state_t state_reg;
    cmr3d_pkg::state_t state_next;
    logic [CTR_W-1:0]  ctr_reg;
    logic [CTR_W-1:0]  ctr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmr3d_pkg::ST_LOAD:
            begin
                if (in_valid && last_point)
                begin
                    state_next = cmr3d_pkg::ST_DIV_LOAD;
                end
            end
            cmr3d_pkg::ST_DIV_LOAD:
            begin
                state_next = cmr3d_pkg::ST_DIV;
            end
            cmr3d_pkg::ST_DIV:
            begin
                if (ctr_reg == CTR_W'(SUM_W - 1))
                begin
                    state_next = cmr3d_pkg::ST_CENTER;
                end
            end
            cmr3d_pkg::ST_CENTER:
            begin
                state_next = cmr3d_pkg::ST_SCAN;
            end
            cmr3d_pkg::ST_SCAN:
            begin
                if (ctr_reg == (CTR_W'(count) - CTR_W'(1)))
                begin
                    state_next = cmr3d_pkg::ST_DRAIN;
                end
            end
            cmr3d_pkg::ST_DRAIN:
            begin
                if (ctr_reg == CTR_W'(cmr3d_pkg::DRAIN_CYCLES - 1))
                begin
                    state_next = cmr3d_pkg::ST_SQRT_LOAD;
                end
            end
            cmr3d_pkg::ST_SQRT_LOAD:
            begin
                state_next = cmr3d_pkg::ST_SQRT;
            end
            cmr3d_pkg::ST_SQRT:
            begin
                if (ctr_reg == CTR_W'(R_W - 1))
                begin
                    state_next = cmr3d_pkg::ST_DONE;
                end
            end
            cmr3d_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = cmr3d_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = cmr3d_pkg::ST_LOAD;
            end
        endcase
    end

    assign ctr_next = (state_next != state_reg) ? '0 : ctr_reg + 1'b1;

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            cmr3d_pkg::ST_LOAD:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            cmr3d_pkg::ST_DIV_LOAD:   cmd.div_load    = 1'b1;
            cmr3d_pkg::ST_DIV:        cmd.div_step    = 1'b1;
            cmr3d_pkg::ST_CENTER:     cmd.center_load = 1'b1;
            cmr3d_pkg::ST_SCAN:       cmd.scan_issue  = 1'b1;
            cmr3d_pkg::ST_DRAIN:      cmd             = '0;
            cmr3d_pkg::ST_SQRT_LOAD:  cmd.sqrt_load   = 1'b1;
            cmr3d_pkg::ST_SQRT:       cmd.sqrt_step   = 1'b1;
            cmr3d_pkg::ST_DONE:       cmd.finish      = slot_free;
            default:                  cmd             = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmr3d_pkg::ST_LOAD;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scan_addr = ctr_reg[ADDR_W-1:0];

endmodule

>>> rtl/centroid_max_radius_3d_top.sv
// ----------------------------------------------------------------------------
// centroid_max_radius_3d_top
// Centroid of a 3D point set and floor of the largest distance from it.
//
//   channel  handshake            word
//   input    in_valid / in_stall  point_x, point_y, point_z, last_point
//   output   out_valid/out_stall  center_x/y/z, max_distance, overflowed
//
// Loading takes one cycle per point. After a closing point the block runs
// SUM_W = COORD_WIDTH + clog2(MAX_POINTS+1) divider steps, N store reads,
// the drain and R_W root steps (R_W = root bits). in_stall is high from the
// close until the result enters the output register. The store is not
// cleared at reset; only entries written in the current set are read.
// ----------------------------------------------------------------------------
module centroid_max_radius_3d_top #(
    parameter int MAX_POINTS  = cmr3d_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = cmr3d_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] center_x,
    output logic signed [COORD_WIDTH-1:0] center_y,
    output logic signed [COORD_WIDTH-1:0] center_z,
    output logic [COORD_WIDTH:0]          max_distance,
    output logic                          overflowed
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    cmr3d_pkg::cmd_t   cmd;
    logic [ADDR_W-1:0] scan_addr;
    logic [CNT_W-1:0]  count;

    cmr3d_ctrl #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .out_stall  (out_stall),
        .count      (count),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd),
        .scan_addr  (scan_addr)
    );

    cmr3d_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .scan_addr    (scan_addr),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .count        (count),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .max_distance (max_distance),
        .overflowed   (overflowed)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_scan_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (CNT_W'(scan_addr) < count))
        else $error("scan reads an entry outside the current set");

    a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_point) |=> cmd.div_load)
        else $error("closing word did not start the division");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result raised without a finish command");
`endif

endmodule

>>> bench/centroid_max_radius_3d_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centroid_max_radius_3d_top_test
// Self-checking bench for the centroid and max-radius block. A short table of
// point sets covers extremes and truncation toward zero, some rows with a
// hand-computed result. Then random sets of mixed spread, with random idling
// on both channels. Result words are checked against the hand-computed value
// where a row gives one, else against a behavioral predictor.
// ----------------------------------------------------------------------------
module centroid_max_radius_3d_top_test;

    localparam int CW           = cmr3d_pkg::COORD_WIDTH_DEF;
    localparam int CAPACITY     = cmr3d_pkg::MAX_POINTS_DEF;
    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_ITEMS  = 60;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIRECTED   = 21;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [CW:0]          dist_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_SMALL,
        SPREAD_EXTREME,
        SPREAD_CLUSTER
    } spread_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        coord_t cz;
        dist_t  reach;
        logic   ovf;
    } summary_t;

    typedef struct packed {
        coord_t   x;
        coord_t   y;
        coord_t   z;
        logic     last;
        logic     typed;
        summary_t want;
    } stim_row_t;

    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_A5  = coord_t'(24'h555555);
    localparam coord_t C_5A  = coord_t'(24'hAAAAAA);

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{24'sd0,    24'sd0,     24'sd0,    1'b1, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 25'd0, 1'b0}},
        '{C_MAX,     C_MAX,      C_MAX,     1'b1, 1'b1, '{C_MAX, C_MAX, C_MAX, 25'd0, 1'b0}},
        '{C_MIN,     C_MIN,      C_MIN,     1'b1, 1'b1, '{C_MIN, C_MIN, C_MIN, 25'd0, 1'b0}},
        '{C_MIN,     C_MIN,      C_MIN,     1'b0, 1'b0, '0},
        '{C_MAX,     C_MAX,      C_MAX,     1'b1, 1'b0, '0},
        '{24'sd256,  24'sd0,     24'sd0,    1'b0, 1'b0, '0},
        '{-24'sd256, 24'sd0,     24'sd0,    1'b1, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 25'd256, 1'b0}},
        '{24'sd0,    24'sd0,     24'sd0,    1'b0, 1'b0, '0},
        '{24'sd768,  24'sd1024,  24'sd0,    1'b1, 1'b1,
          '{24'sd384, 24'sd512, 24'sd0, 25'd640, 1'b0}},
        '{-24'sd1,   -24'sd1,    -24'sd1,   1'b0, 1'b0, '0},
        '{-24'sd2,   24'sd0,     24'sd0,    1'b0, 1'b0, '0},
        '{24'sd0,    24'sd0,     24'sd0,    1'b1, 1'b0, '0},
        '{C_A5,      C_5A,       C_A5,      1'b0, 1'b0, '0},
        '{C_5A,      C_A5,       C_5A,      1'b0, 1'b0, '0},
        '{C_MAX,     C_MIN,      24'sd0,    1'b0, 1'b0, '0},
        '{C_MIN,     C_MAX,      24'sd1,    1'b1, 1'b0, '0},
        '{24'sd1000, -24'sd2000, 24'sd3000, 1'b1, 1'b1,
          '{24'sd1000, -24'sd2000, 24'sd3000, 25'd0, 1'b0}},
        '{24'sd100,  24'sd200,   24'sd300,  1'b0, 1'b0, '0},
        '{C_MAX,     24'sd0,     C_MIN,     1'b0, 1'b0, '0},
        '{-24'sd7,   24'sd13,    -24'sd21,  1'b0, 1'b0, '0},
        '{24'sd0,    24'sd0,     24'sd0,    1'b1, 1'b0, '0}
    };

    logic   clk;
    logic   rst_n      = 1'b0;
    logic   in_valid   = 1'b0;
    logic   in_stall;
    coord_t point_x    = '0;
    coord_t point_y    = '0;
    coord_t point_z    = '0;
    logic   last_point = 1'b0;
    logic   out_valid;
    logic   out_stall  = 1'b0;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    dist_t  max_distance;
    logic   overflowed;

    coord_t   held_x[$];
    coord_t   held_y[$];
    coord_t   held_z[$];
    longint   acc_x        = 0;
    longint   acc_y        = 0;
    longint   acc_z        = 0;
    logic     dropped      = 1'b0;
    summary_t pending_results[$];

    int fail_count   = 0;
    int cycles       = 0;
    int items_sent   = 0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    centroid_max_radius_3d_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .max_distance (max_distance),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("centroid_max_radius_3d_top verification failed");
        $finish;
    end

    function automatic dist_t floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= n)
                root = trial;
        end
        return dist_t'(root);
    endfunction

    task automatic predict_point(input coord_t x, input coord_t y, input coord_t z,
                                 input logic last, output logic closed,
                                 output summary_t res);
        longint          n;
        longint          mx;
        longint          my;
        longint          mz;
        longint          dx;
        longint          dy;
        longint          dz;
        longint unsigned d2;
        longint unsigned best;
        closed = 1'b0;
        res    = '0;
        mx     = 0;
        my     = 0;
        mz     = 0;
        best   = 0;
        if (held_x.size() < CAPACITY)
        begin
            held_x.push_back(x);
            held_y.push_back(y);
            held_z.push_back(z);
            acc_x += x;
            acc_y += y;
            acc_z += z;
        end
        else
            dropped = 1'b1;
        if (last)
        begin
            closed = 1'b1;
            n = held_x.size();
            if (n != 0)
            begin
                mx = acc_x / n;
                my = acc_y / n;
                mz = acc_z / n;
                foreach (held_x[i])
                begin
                    dx = held_x[i] - mx;
                    dy = held_y[i] - my;
                    dz = held_z[i] - mz;
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    if (dz < 0) dz = -dz;
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (d2 > best)
                        best = d2;
                end
            end
            res.cx    = coord_t'(mx);
            res.cy    = coord_t'(my);
            res.cz    = coord_t'(mz);
            res.reach = floor_root(best);
            res.ovf   = dropped;
            held_x.delete();
            held_y.delete();
            held_z.delete();
            acc_x   = 0;
            acc_y   = 0;
            acc_z   = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic last, input logic typed, input summary_t want);
        int       gap;
        logic     closed;
        summary_t res;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        point_z    <= z;
        last_point <= last;
        do @(posedge clk); while (in_stall);
        predict_point(x, y, z, last, closed, res);
        if (closed)
            pending_results.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic coord_t rand_coord(input spread_t spread, input coord_t base);
        case (spread)
            SPREAD_FULL:  return coord_t'($urandom);
            SPREAD_SMALL: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
            SPREAD_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            default:      return base + coord_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic run_set(input int n, input spread_t spread);
        coord_t bx;
        coord_t by;
        coord_t bz;
        bx = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        by = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        bz = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        for (int k = 0; k < n; k++)
            send_point(rand_coord(spread, bx), rand_coord(spread, by),
                       rand_coord(spread, bz), k == n - 1, 1'b0, '0);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
            if (quiet && stall_left <= 6)
                stall_left = 0;
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        summary_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no point set closed");
                fail_count++;
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (center_x !== exp_word.cx)
                begin
                    $error("center_x: expected %0d, actual %0d", exp_word.cx, center_x);
                    fail_count++;
                end
                if (center_y !== exp_word.cy)
                begin
                    $error("center_y: expected %0d, actual %0d", exp_word.cy, center_y);
                    fail_count++;
                end
                if (center_z !== exp_word.cz)
                begin
                    $error("center_z: expected %0d, actual %0d", exp_word.cz, center_z);
                    fail_count++;
                end
                if (max_distance !== exp_word.reach)
                begin
                    $error("max_distance: expected %0d, actual %0d", exp_word.reach,
                           max_distance);
                    fail_count++;
                end
                if (overflowed !== exp_word.ovf)
                begin
                    $error("overflowed: expected %0d, actual %0d", exp_word.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int      base;
        bit      paused;
        int      size;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
            send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z, DIRECTED[r].last,
                       DIRECTED[r].typed, DIRECTED[r].want);
        drain_results();

        base         = items_sent;
        hold_request = 1'b1;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (!paused && items_sent - base >= RANDOM_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            run_set(size, spread_t'($urandom_range(0, 3)));
        end
        drain_results();

        repeat (cmr3d_pkg::DRAIN_CYCLES + 100) @(posedge clk);
        if (fail_count == 0)
            $display("centroid_max_radius_3d_top verification clean");
        else
            $display("centroid_max_radius_3d_top verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cmr3d_pkg.sv
rtl/cmr3d_dp.sv
rtl/cmr3d_ctrl.sv
rtl/centroid_max_radius_3d_top.sv
bench/centroid_max_radius_3d_top_test.sv
